@@ hw/rtl/rbp_pkg.sv @@
// ----------------------------------------------------------------------------
// Radix bucket partition package
// Shared widths, operation codes, result kinds and the command queue entry.
// ----------------------------------------------------------------------------
package rbp_pkg;

    localparam int MAX_BUCKET_BITS = 16;
    localparam int BUCKET_W        = MAX_BUCKET_BITS;
    localparam int NUM_BUCKETS     = 1 << MAX_BUCKET_BITS;
    localparam int INDEX_W         = MAX_BUCKET_BITS + 1;
    localparam int KEY_W           = 32;
    localparam int VALUE_W         = 64;
    localparam int CFG_W           = 5;
    localparam int ADDR_W          = 3;

    // Input operation codes.
    localparam logic [2:0] OP_COUNT   = 3'd0;
    localparam logic [2:0] OP_SCAN    = 3'd1;
    localparam logic [2:0] OP_SCATTER = 3'd2;
    localparam logic [2:0] OP_READ    = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_RECORD = 2'd0;
    localparam logic [1:0] KIND_TOTAL  = 2'd1;
    localparam logic [1:0] KIND_START  = 2'd2;

    // Register byte addresses.
    localparam logic [ADDR_W-1:0] ADDR_OFFSET = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_COUNT  = 3'd4;

    // Commands after classification by the front end.
    typedef enum logic [2:0] {
        CMD_COUNT,
        CMD_SCAN,
        CMD_SCATTER,
        CMD_START,
        CMD_TOTAL,
        CMD_CLEAR
    } cmd_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic                 err;
        logic [BUCKET_W-1:0]  bucket;
        logic [KEY_W-1:0]     key;
        logic [VALUE_W-1:0]   value;
        logic [KEY_W-1:0]     value_two;
    } q_entry_t;

    typedef struct packed {
        logic pop;
        logic init_busy;
    } back_ctl_t;

endpackage

@@ hw/rtl/rbp_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage array; read data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/rbp_front.sv @@
// ----------------------------------------------------------------------------
// Radix bucket partition front end
// Accepts items, checks the registers, extracts the bucket and queues commands.
// ----------------------------------------------------------------------------
module rbp_front
    import rbp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          opcode,
    input  logic [KEY_W-1:0]    key,
    input  logic [VALUE_W-1:0]  value,
    input  logic [KEY_W-1:0]    value_two,
    input  logic [INDEX_W-1:0]  bucket_index,
    input  logic [CFG_W-1:0]    cfg_offset,
    input  logic [CFG_W-1:0]    cfg_bits,
    input  back_ctl_t           back_ctl,
    output logic                q_valid,
    output q_entry_t            q_entry
);

    logic              regs_bad;
    logic [5:0]        field_end;
    logic [KEY_W-1:0]  field_mask;
    logic [KEY_W-1:0]  shifted_key;
    logic [INDEX_W-1:0] live_buckets;
    q_entry_t          new_entry;
    logic              push;
    logic              keep;
    logic              accept;

    q_entry_t          fifo_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;

    // Register check and bucket field extraction.
    assign field_end    = {1'b0, cfg_offset} + {1'b0, cfg_bits};
    assign regs_bad     = (cfg_bits == '0) || (cfg_bits > CFG_W'(MAX_BUCKET_BITS)) ||
                          (field_end > 6'd32);
    assign field_mask   = (32'd1 << cfg_bits) - 32'd1;
    assign shifted_key  = (key >> cfg_offset) & field_mask;
    assign live_buckets = INDEX_W'(1) << cfg_bits;

    // Classification of the incoming item.
    always_comb
    begin
        new_entry           = '0;
        new_entry.err       = regs_bad;
        new_entry.key       = key;
        new_entry.value     = value;
        new_entry.value_two = value_two;
        new_entry.bucket    = shifted_key[BUCKET_W-1:0];
        keep                = 1'b1;
        unique case (opcode)
            OP_COUNT:
            begin
                new_entry.cmd = CMD_COUNT;
                keep          = !regs_bad;
            end
            OP_SCAN:
            begin
                new_entry.cmd = CMD_SCAN;
            end
            OP_SCATTER:
            begin
                new_entry.cmd = CMD_SCATTER;
            end
            OP_READ:
            begin
                new_entry.bucket = bucket_index[BUCKET_W-1:0];
                if (!regs_bad && bucket_index >= live_buckets)
                begin
                    new_entry.cmd = CMD_TOTAL;
                end
                else
                begin
                    new_entry.cmd = CMD_START;
                end
            end
            OP_CLEAR:
            begin
                new_entry.cmd = CMD_CLEAR;
                keep          = !regs_bad;
            end
            default:
            begin
                new_entry.cmd = CMD_COUNT;
                keep          = 1'b0;
            end
        endcase
    end

    // Two-entry command queue between the front and the back.
    assign in_ready = (count_reg != 2'd2) && !back_ctl.init_busy;
    assign accept   = in_valid && in_ready;
    assign push     = accept && keep;
    assign q_valid  = (count_reg != 2'd0);
    assign q_entry  = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ back_ctl.pop;
        count_next  = count_reg + 2'(push) - 2'(back_ctl.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

@@ hw/rtl/rbp_back.sv @@
// ----------------------------------------------------------------------------
// Radix bucket partition back end
// Executes queued commands on the counter and start memories and drives results.
// ----------------------------------------------------------------------------
module rbp_back
    import rbp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CFG_W-1:0]    cfg_bits,
    input  logic                q_valid,
    input  q_entry_t            q_entry,
    output back_ctl_t           back_ctl,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          result_kind,
    output logic [KEY_W-1:0]    position,
    output logic [KEY_W-1:0]    key_out,
    output logic [VALUE_W-1:0]  value_out,
    output logic [KEY_W-1:0]    value_two_out,
    output logic                overflow,
    output logic                config_error
);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_CLEAR     = 7'b0000010,
        ST_CNT       = 7'b0000100,
        ST_SCT       = 7'b0001000,
        ST_SCAN      = 7'b0010000,
        ST_SCAN_DONE = 7'b0100000,
        ST_QRD       = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    q_entry_t            cur_reg, cur_next;
    logic [BUCKET_W-1:0] ptr_reg, ptr_next;
    logic [KEY_W-1:0]    cum_reg, cum_next;
    logic                cum_ovf_reg, cum_ovf_next;
    logic [KEY_W-1:0]    total_lo_reg, total_lo_next;
    logic                total_sat_reg, total_sat_next;
    logic                ovf_flag_reg, ovf_flag_next;

    logic                out_valid_reg;
    logic [1:0]          kind_reg;
    logic [KEY_W-1:0]    pos_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [KEY_W-1:0]    value_two_reg;
    logic                ovf_out_reg;
    logic                err_out_reg;

    logic                out_free;
    logic                load;
    logic [1:0]          ld_kind;
    logic [KEY_W-1:0]    ld_pos;
    logic                ld_record;
    logic                ld_ovf;
    logic                ld_err;

    logic                cnt_we, cnt_re;
    logic [BUCKET_W-1:0] cnt_waddr, cnt_raddr;
    logic [KEY_W-1:0]    cnt_wdata, cnt_rdata;
    logic                st_we, st_re;
    logic [BUCKET_W-1:0] st_raddr;
    logic [KEY_W-1:0]    st_rdata;

    logic [BUCKET_W-1:0] bucket_mask;
    logic [KEY_W-1:0]    total_view;
    logic [KEY_W:0]      cum_sum;
    logic                pop;

    // Bucket counters, also used as scatter cursors after a scan.
    rbp_ram #(.WIDTH(KEY_W), .DEPTH(NUM_BUCKETS)) u_counters (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // Bucket start table, written by the scan.
    rbp_ram #(.WIDTH(KEY_W), .DEPTH(NUM_BUCKETS)) u_starts (
        .clk   (clk),
        .we    (st_we),
        .waddr (ptr_reg),
        .wdata (cum_reg),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign bucket_mask = BUCKET_W'((INDEX_W'(1) << cfg_bits) - INDEX_W'(1));
    assign total_view  = total_sat_reg ? '1 : total_lo_reg;
    assign cum_sum     = {1'b0, cum_reg} + {1'b0, cnt_rdata};
    assign out_free    = !out_valid_reg || out_ready;

    // Command sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        ptr_next       = ptr_reg;
        cum_next       = cum_reg;
        cum_ovf_next   = cum_ovf_reg;
        total_lo_next  = total_lo_reg;
        total_sat_next = total_sat_reg;
        ovf_flag_next  = ovf_flag_reg;
        pop            = 1'b0;
        load           = 1'b0;
        ld_kind        = KIND_RECORD;
        ld_pos         = '0;
        ld_record      = 1'b0;
        ld_ovf         = ovf_flag_reg;
        ld_err         = 1'b0;
        cnt_we         = 1'b0;
        cnt_waddr      = cur_reg.bucket;
        cnt_wdata      = cnt_rdata + 32'd1;
        cnt_re         = 1'b0;
        cnt_raddr      = q_entry.bucket;
        st_we          = 1'b0;
        st_re          = 1'b0;
        st_raddr       = q_entry.bucket;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_entry.cmd)
                        CMD_COUNT:
                        begin
                            pop        = 1'b1;
                            cur_next   = q_entry;
                            cnt_re     = 1'b1;
                            state_next = ST_CNT;
                        end
                        CMD_SCATTER, CMD_SCAN, CMD_START:
                        begin
                            if (q_entry.err)
                            begin
                                // Invalid registers: zero payload, error flag set.
                                if (out_free)
                                begin
                                    pop    = 1'b1;
                                    load   = 1'b1;
                                    ld_err = 1'b1;
                                    ld_kind = (q_entry.cmd == CMD_SCAN) ? KIND_TOTAL :
                                              (q_entry.cmd == CMD_START) ? KIND_START :
                                              KIND_RECORD;
                                end
                            end
                            else
                            begin
                                pop      = 1'b1;
                                cur_next = q_entry;
                                if (q_entry.cmd == CMD_SCATTER)
                                begin
                                    cnt_re     = 1'b1;
                                    state_next = ST_SCT;
                                end
                                else if (q_entry.cmd == CMD_START)
                                begin
                                    st_re      = 1'b1;
                                    state_next = ST_QRD;
                                end
                                else
                                begin
                                    cnt_re       = 1'b1;
                                    cnt_raddr    = '0;
                                    ptr_next     = '0;
                                    cum_next     = '0;
                                    cum_ovf_next = 1'b0;
                                    state_next   = ST_SCAN;
                                end
                            end
                        end
                        CMD_TOTAL:
                        begin
                            if (out_free)
                            begin
                                pop     = 1'b1;
                                load    = 1'b1;
                                ld_kind = KIND_START;
                                ld_pos  = total_view;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            pop            = 1'b1;
                            ptr_next       = '0;
                            total_lo_next  = '0;
                            total_sat_next = 1'b0;
                            ovf_flag_next  = 1'b0;
                            state_next     = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = ptr_reg;
                cnt_wdata = '0;
                ptr_next  = ptr_reg + BUCKET_W'(1);
                if (ptr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CNT:
            begin
                cnt_we = 1'b1;
                if (cnt_rdata == '1)
                begin
                    ovf_flag_next = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_SCT:
            begin
                if (out_free)
                begin
                    cnt_we     = 1'b1;
                    load       = 1'b1;
                    ld_kind    = KIND_RECORD;
                    ld_pos     = cnt_rdata;
                    ld_record  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                // Counter of bucket ptr arrives; store its start and fetch the next.
                cnt_we       = 1'b1;
                cnt_waddr    = ptr_reg;
                cnt_wdata    = cum_reg;
                st_we        = 1'b1;
                cum_next     = cum_sum[KEY_W-1:0];
                cum_ovf_next = cum_ovf_reg | cum_sum[KEY_W];
                if (ptr_reg == bucket_mask)
                begin
                    state_next = ST_SCAN_DONE;
                end
                else
                begin
                    cnt_re    = 1'b1;
                    cnt_raddr = ptr_reg + BUCKET_W'(1);
                    ptr_next  = ptr_reg + BUCKET_W'(1);
                end
            end
            ST_SCAN_DONE:
            begin
                if (out_free)
                begin
                    total_lo_next  = cum_reg;
                    total_sat_next = cum_ovf_reg;
                    ovf_flag_next  = ovf_flag_reg | cum_ovf_reg;
                    load           = 1'b1;
                    ld_kind        = KIND_TOTAL;
                    ld_pos         = cum_ovf_reg ? '1 : cum_reg;
                    ld_ovf         = ovf_flag_reg | cum_ovf_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_QRD:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    ld_kind    = KIND_START;
                    ld_pos     = st_rdata;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state; reset starts a clearing pass over the counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ptr_reg       <= '0;
            cum_ovf_reg   <= 1'b0;
            total_lo_reg  <= '0;
            total_sat_reg <= 1'b0;
            ovf_flag_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            cum_ovf_reg   <= cum_ovf_next;
            total_lo_reg  <= total_lo_next;
            total_sat_reg <= total_sat_next;
            ovf_flag_reg  <= ovf_flag_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        cum_reg <= cum_next;
        if (load)
        begin
            kind_reg      <= ld_kind;
            pos_reg       <= ld_pos;
            key_reg       <= ld_record ? cur_reg.key : '0;
            value_reg     <= ld_record ? cur_reg.value : '0;
            value_two_reg <= ld_record ? cur_reg.value_two : '0;
            ovf_out_reg   <= ld_ovf;
            err_out_reg   <= ld_err;
        end
    end

    assign back_ctl.pop       = pop;
    assign back_ctl.init_busy = (state_reg == ST_CLEAR);
    assign out_valid          = out_valid_reg;
    assign result_kind        = kind_reg;
    assign position           = pos_reg;
    assign key_out            = key_reg;
    assign value_out          = value_reg;
    assign value_two_out      = value_two_reg;
    assign overflow           = ovf_out_reg;
    assign config_error       = err_out_reg;

    // Checks on the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("back end state is not one-hot");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_valid)
        else $error("queue popped while empty");
    assert property (@(posedge clk) disable iff (!rst_n) load |-> out_free)
        else $error("result loaded over an untaken result");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (ptr_reg <= bucket_mask))
        else $error("scan pointer beyond the last bucket");

endmodule

@@ hw/rtl/radix_bucket_partition_two_values_unit.sv @@
// ----------------------------------------------------------------------------
// Radix bucket partition unit
// Counts, scans and scatters records into buckets chosen by a key bit field.
// ----------------------------------------------------------------------------
// After reset the unit sweeps its whole counter memory to zero and holds
// in_ready low; a clear operation does the same sweep. Count reads and
// writes back one counter, scatter reads and advances one counter, a bucket
// start read reads the start table, and a read of the total and error
// answers need no memory access. A scan walks the 2^bucket_bit_count
// buckets in turn. A two-entry queue lets items be taken while earlier
// work finishes, and a result register holds each transfer until out_ready.
module radix_bucket_partition_two_values_unit
    import rbp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          opcode,
    input  logic [KEY_W-1:0]    key,
    input  logic [VALUE_W-1:0]  value,
    input  logic [KEY_W-1:0]    value_two,
    input  logic [INDEX_W-1:0]  bucket_index,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          result_kind,
    output logic [KEY_W-1:0]    position,
    output logic [KEY_W-1:0]    key_out,
    output logic [VALUE_W-1:0]  value_out,
    output logic [KEY_W-1:0]    value_two_out,
    output logic                overflow,
    output logic                config_error
);

    logic [CFG_W-1:0] offset_reg;
    logic [CFG_W-1:0] bits_reg;
    logic             wr_en;
    logic             q_valid;
    q_entry_t         q_entry;
    back_ctl_t        back_ctl;

    // Configuration registers.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            bits_reg   <= CFG_W'(8);
        end
        else if (wr_en)
        begin
            unique case (paddr)
                ADDR_OFFSET: offset_reg <= pwdata[CFG_W-1:0];
                ADDR_COUNT:  bits_reg   <= pwdata[CFG_W-1:0];
                default:     offset_reg <= offset_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_OFFSET: prdata = {27'd0, offset_reg};
            ADDR_COUNT:  prdata = {27'd0, bits_reg};
            default:     prdata = '0;
        endcase
    end

    rbp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .key          (key),
        .value        (value),
        .value_two    (value_two),
        .bucket_index (bucket_index),
        .cfg_offset   (offset_reg),
        .cfg_bits     (bits_reg),
        .back_ctl     (back_ctl),
        .q_valid      (q_valid),
        .q_entry      (q_entry)
    );

    rbp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_bits      (bits_reg),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .back_ctl      (back_ctl),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .position      (position),
        .key_out       (key_out),
        .value_out     (value_out),
        .value_two_out (value_two_out),
        .overflow      (overflow),
        .config_error  (config_error)
    );

endmodule

@@ dv/rbp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix bucket partition checker
// Watches the register port and both streaming channels, keeps its own copy
// of the bucket counters, start table and flags, predicts every result and
// compares each result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module rbp_checker
    import rbp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [2:0]          opcode,
    input  logic [KEY_W-1:0]    key,
    input  logic [VALUE_W-1:0]  value,
    input  logic [KEY_W-1:0]    value_two,
    input  logic [INDEX_W-1:0]  bucket_index,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [1:0]          result_kind,
    input  logic [KEY_W-1:0]    position,
    input  logic [KEY_W-1:0]    key_out,
    input  logic [VALUE_W-1:0]  value_out,
    input  logic [KEY_W-1:0]    value_two_out,
    input  logic                overflow,
    input  logic                config_error,
    output int                  fail_count,
    output int                  pending,
    output int                  result_count
);

    typedef struct packed {
        logic [1:0]         kind;
        logic [KEY_W-1:0]   pos;
        logic [KEY_W-1:0]   rec_key;
        logic [VALUE_W-1:0] rec_value;
        logic [KEY_W-1:0]   rec_value_two;
        logic               ovf;
        logic               err;
    } partition_result_t;

    // Mirror of the block state.
    logic [31:0]        cursor_mem [0:NUM_BUCKETS-1];
    logic [31:0]        start_mem  [0:NUM_BUCKETS-1];
    logic [32:0]        item_total;
    logic               ovf_flag;
    logic [CFG_W-1:0]   bit_offset;
    logic [CFG_W-1:0]   bit_count;

    partition_result_t  expected_results [$];

    function automatic logic regs_invalid();
        return (bit_count < 1) || (bit_count > MAX_BUCKET_BITS) ||
               ({1'b0, bit_offset} + {1'b0, bit_count} > 6'd32);
    endfunction

    function automatic logic [31:0] key_bucket(logic [31:0] k);
        logic [31:0] mask;
        mask = (32'd1 << bit_count) - 32'd1;
        return (k >> bit_offset) & mask;
    endfunction

    function automatic logic [31:0] total_view();
        return item_total[32] ? 32'hFFFF_FFFF : item_total[31:0];
    endfunction

    task automatic clear_counters();
        for (int b = 0; b < NUM_BUCKETS; b++)
            cursor_mem[b] = '0;
        item_total = '0;
        ovf_flag   = 1'b0;
    endtask

    // Applies one accepted item and queues the result that it causes.
    task automatic apply_item(logic [2:0] op, logic [31:0] k, logic [63:0] v,
                              logic [31:0] v2, logic [INDEX_W-1:0] idx);
        partition_result_t r;
        logic [31:0]       b;
        logic [63:0]       cum;
        logic [31:0]       c;
        int                nb;
        r  = '0;
        nb = 1 << bit_count;
        if (op > OP_CLEAR)
            return;
        if (regs_invalid()) begin
            // Invalid registers: no state changes, answers flag the error.
            r.err = 1'b1;
            r.ovf = ovf_flag;
            case (op)
                OP_SCAN:    r.kind = KIND_TOTAL;
                OP_SCATTER: r.kind = KIND_RECORD;
                OP_READ:    r.kind = KIND_START;
                default:    return;
            endcase
            expected_results.push_back(r);
            return;
        end
        case (op)
            OP_COUNT: begin
                b = key_bucket(k);
                cursor_mem[b] = cursor_mem[b] + 32'd1;
                if (cursor_mem[b] == 32'd0)
                    ovf_flag = 1'b1;
            end
            OP_SCAN: begin
                cum = '0;
                for (int i = 0; i < nb; i++) begin
                    c = cursor_mem[i];
                    start_mem[i]  = cum[31:0];
                    cursor_mem[i] = cum[31:0];
                    cum = cum + 64'(c);
                end
                if (cum >= 64'h1_0000_0000) begin
                    ovf_flag = 1'b1;
                    cum = 64'h1_0000_0000;
                end
                item_total = cum[32:0];
                r.kind = KIND_TOTAL;
                r.pos  = total_view();
                r.ovf  = ovf_flag;
                expected_results.push_back(r);
            end
            OP_SCATTER: begin
                b = key_bucket(k);
                r.kind          = KIND_RECORD;
                r.pos           = cursor_mem[b];
                r.rec_key       = k;
                r.rec_value     = v;
                r.rec_value_two = v2;
                r.ovf           = ovf_flag;
                cursor_mem[b]   = cursor_mem[b] + 32'd1;
                expected_results.push_back(r);
            end
            OP_READ: begin
                r.kind = KIND_START;
                r.pos  = (idx < nb) ? start_mem[idx] : total_view();
                r.ovf  = ovf_flag;
                expected_results.push_back(r);
            end
            default: clear_counters();
        endcase
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count   = 0;
        result_count = 0;
        pending      = 0;
        for (int b = 0; b < NUM_BUCKETS; b++)
            start_mem[b] = '0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        partition_result_t e;
        if (!rst_n) begin
            clear_counters();
            bit_offset = '0;
            bit_count  = 5'd8;
            expected_results.delete();
        end
        else begin
            // Result transfers belong to earlier items, so compare them first.
            if (out_valid && out_ready) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    $error("result transfer with no expected result waiting");
                    fail_count++;
                end
                else begin
                    e = expected_results.pop_front();
                    check_field("result_kind", 64'(e.kind), 64'(result_kind));
                    check_field("position", 64'(e.pos), 64'(position));
                    check_field("key_out", 64'(e.rec_key), 64'(key_out));
                    check_field("value_out", e.rec_value, value_out);
                    check_field("value_two_out", 64'(e.rec_value_two), 64'(value_two_out));
                    check_field("overflow", 64'(e.ovf), 64'(overflow));
                    check_field("config_error", 64'(e.err), 64'(config_error));
                end
            end

            // Register writes.
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_OFFSET)
                    bit_offset = pwdata[CFG_W-1:0];
                else if (paddr == ADDR_COUNT)
                    bit_count = pwdata[CFG_W-1:0];
            end

            // Input transfers.
            if (in_valid && in_ready)
                apply_item(opcode, key, value, value_two, bucket_index);
        end
        pending = expected_results.size();
    end

endmodule

@@ dv/tb_radix_bucket_partition_two_values_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix bucket partition unit testbench
// Drives directed and random count / scan / scatter / read / clear traffic
// through a series of bucket field settings, valid and invalid, with random
// gaps on both channels and one long output stall; the checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb_radix_bucket_partition_two_values_unit;
    import rbp_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         opcode;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [KEY_W-1:0]   value_two;
    logic [INDEX_W-1:0] bucket_index;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         result_kind;
    logic [KEY_W-1:0]   position;
    logic [KEY_W-1:0]   key_out;
    logic [VALUE_W-1:0] value_out;
    logic [KEY_W-1:0]   value_two_out;
    logic               overflow;
    logic               config_error;

    int                 fail_count;
    int                 pending;
    int                 result_count;

    // Stimulus bookkeeping: the start table may only be read where a scan
    // has written it.
    int                 cur_offset;
    int                 cur_bits;
    int                 scanned_buckets;
    int                 items_sent;
    int                 settings_run;
    logic               send_gaps;

    localparam logic [2:0]         OP_UNUSED_LO = 3'd5;
    localparam logic [2:0]         OP_UNUSED_HI = 3'd7;
    localparam logic [INDEX_W-1:0] INDEX_MAX    = '1;

    radix_bucket_partition_two_values_unit u_top (.*);

    rbp_checker u_checker (.*);

    // Clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit.
    initial
    begin
        #200_000_000;
        $display("tb_radix_bucket_partition_two_values_unit NOT OK");
        $finish;
    end

    function automatic logic cfg_valid();
        return cur_bits >= 1 && cur_bits <= MAX_BUCKET_BITS && cur_offset + cur_bits <= 32;
    endfunction

    // Any read index, in range of the port.
    function automatic logic [INDEX_W-1:0] rand_index();
        return INDEX_W'($urandom_range(0, INDEX_MAX));
    endfunction

    // Index for a read: a scanned bucket, the bucket count or above, or any index under invalid registers.
    function automatic logic [INDEX_W-1:0] pick_index();
        int nb;
        int lim;
        nb = 1 << cur_bits;
        if (!cfg_valid())
            return rand_index();
        lim = (scanned_buckets < nb) ? scanned_buckets : nb;
        if (lim > 0 && $urandom_range(0, 2) != 0)
            return INDEX_W'($urandom_range(0, lim - 1));
        return INDEX_W'($urandom_range(nb, INDEX_MAX));
    endfunction

    // Key with the bucket field replaced.
    function automatic logic [31:0] key_in_bucket(logic [31:0] k, int b);
        logic [63:0] mask;
        mask = ((64'd1 << cur_bits) - 64'd1) << cur_offset;
        return (k & ~mask[31:0]) | ((b << cur_offset) & mask[31:0]);
    endfunction

    task automatic send_item(logic [2:0] op, logic [31:0] k, logic [63:0] v,
                             logic [31:0] v2, logic [INDEX_W-1:0] idx);
        int gap;
        gap = send_gaps ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        key          <= k;
        value        <= v;
        value_two    <= v2;
        bucket_index <= idx;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if (op == OP_SCAN && cfg_valid() && (1 << cur_bits) > scanned_buckets)
            scanned_buckets = 1 << cur_bits;
    endtask

    task automatic send_random_item();
        logic [2:0] op;
        op = 3'($urandom_range(0, 7));
        send_item(op, $urandom, {$urandom, $urandom}, $urandom,
                  (op == OP_READ) ? pick_index() : rand_index());
    endtask

    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Ends a phase with a read at the top index (the total, or an error answer under invalid
    // registers), whose answer follows all earlier work, then waits for every expected result.
    task automatic drain();
        send_item(OP_READ, $urandom, {$urandom, $urandom}, $urandom, INDEX_MAX);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(int off, int bits);
        cur_offset = off;
        cur_bits   = bits;
        write_reg(ADDR_OFFSET, off);
        write_reg(ADDR_COUNT, bits);
        settings_run++;
    endtask

    // Count a set of keys, scan, scatter them in a shuffled order, read back.
    task automatic sort_batch();
        logic [31:0] keys [$];
        int          n;
        int          nb;
        int          pool;
        nb   = 1 << cur_bits;
        pool = (nb < 6) ? nb - 1 : 5;
        n    = $urandom_range(2, 12);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) != 0)
                keys.push_back(key_in_bucket($urandom, $urandom_range(0, pool)));
            else
                keys.push_back($urandom);
        end
        foreach (keys[i])
            send_item(OP_COUNT, keys[i], {$urandom, $urandom}, $urandom, rand_index());
        send_item(OP_SCAN, $urandom, {$urandom, $urandom}, $urandom, rand_index());
        keys.shuffle();
        foreach (keys[i])
            send_item(OP_SCATTER, keys[i], {$urandom, $urandom}, $urandom, rand_index());
        repeat (2)
            send_item(OP_READ, $urandom, {$urandom, $urandom}, $urandom, pick_index());
        repeat ($urandom_range(1, 5))
            send_random_item();
    endtask

    task automatic random_phase(int off, int bits, logic with_clear, int batches);
        set_config(off, bits);
        send_gaps = $urandom_range(0, 3) != 0;
        if (with_clear)
            send_item(OP_CLEAR, $urandom, {$urandom, $urandom}, $urandom, '0);
        repeat (batches)
            sort_batch();
        drain();
    endtask

    // Every operation, and the unused codes, under invalid registers.
    task automatic error_phase(int off, int bits);
        set_config(off, bits);
        send_gaps = 1'b1;
        for (int op = 0; op <= OP_UNUSED_HI; op++)
            send_item(3'(op), $urandom, {$urandom, $urandom}, $urandom, rand_index());
        send_item(OP_READ, 32'hFFFF_FFFF, '1, '1, '0);
        drain();
    endtask

    // Output side: random stalls per transfer, quiet stretches, and one long
    // hold so that the block fills up and stops taking items.
    initial
    begin
        int stall;
        int taken;
        logic rx_gaps;
        taken   = 0;
        rx_gaps = 1'b1;
        out_ready <= 1'b0;
        forever begin
            if (taken % 40 == 0)
                rx_gaps = $urandom_range(0, 2) != 0;
            stall = rx_gaps ? $urandom_range(0, 13) : 0;
            if (taken == 150)
                stall = 400;
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    // Stimulus and verdict.
    initial
    begin
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        in_valid     <= 1'b0;
        opcode       <= OP_COUNT;
        key          <= '0;
        value        <= '0;
        value_two    <= '0;
        bucket_index <= '0;
        cur_offset      = 0;
        cur_bits        = 8;
        scanned_buckets = 0;
        items_sent      = 0;
        settings_run    = 1;
        send_gaps       = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass at the reset setting: field extremes, bucket edges,
        // total reads at and above the bucket count, scatter without a fresh
        // scan, unused codes, and a clear that keeps the start table.
        send_item(OP_COUNT, 32'h0000_0000, '0, '0, '0);
        send_item(OP_COUNT, 32'hFFFF_FFFF, '1, '1, '1);
        send_item(OP_COUNT, 32'h0000_0180, '0, '0, '0);
        send_item(OP_COUNT, 32'hFFFF_FF00, '0, '0, '0);
        send_item(OP_SCAN, '0, '0, '0, '0);
        send_item(OP_READ, '0, '0, '0, 17'd0);
        send_item(OP_READ, '0, '0, '0, 17'd255);
        send_item(OP_READ, '0, '0, '0, 17'd256);
        send_item(OP_READ, '1, '1, '1, INDEX_MAX);
        send_item(OP_SCATTER, 32'h0000_0000, '0, '0, '0);
        send_item(OP_SCATTER, 32'hFFFF_FF00, '1, '1, '0);
        send_item(OP_SCATTER, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF, 32'hA5A5_5A5A, '0);
        send_item(OP_SCATTER, 32'h0000_0180, 64'h8000_0000_0000_0001, 32'h8000_0001, '0);
        for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
            send_item(3'(op), '1, '1, '1, INDEX_MAX);
        send_item(OP_SCATTER, 32'h0000_0000, '1, '0, '0);
        send_item(OP_COUNT, 32'h0000_0000, '0, '0, '0);
        send_item(OP_CLEAR, '0, '0, '0, '0);
        send_item(OP_READ, '0, '0, '0, INDEX_MAX);
        send_item(OP_READ, '0, '0, '0, 17'd128);
        send_item(OP_SCATTER, 32'h0000_0080, '1, '1, '0);
        drain();

        // Invalid settings: field past the key top, zero width, too wide.
        error_phase(31, 8);
        error_phase(0, 0);
        error_phase(0, 17);
        error_phase(31, 31);

        // Valid settings, extremes among them.
        random_phase(0, 1, 1'b0, 4);
        random_phase(31, 1, 1'b0, 3);
        random_phase(4, 4, 1'b1, 4);
        random_phase(28, 4, 1'b0, 3);
        random_phase(16, 16, 1'b1, 1);
        random_phase(12, 12, 1'b0, 3);
        random_phase(24, 8, 1'b0, 4);
        random_phase(3, 5, 1'b0, 4);
        random_phase(0, 8, 1'b0, 4);
        random_phase(10, 2, 1'b0, 3);

        in_valid <= 1'b0;
        repeat (50) @(posedge clk);
        $display("Sent %0d items under %0d register settings, checked %0d results.",
                 items_sent, settings_run, result_count);
        $display("Covered count, scan, scatter, start and total reads, clears, unused codes.");
        if (fail_count == 0 && pending == 0)
            $display("tb_radix_bucket_partition_two_values_unit OK");
        else
            $display("tb_radix_bucket_partition_two_values_unit NOT OK");
        $finish;
    end

endmodule
